/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SFTS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfts assertion failed");

// next-cycle implication
`define SFTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfts assertion failed");

`endif

/* rtl/sfts_pkg.sv */
package sfts_pkg;

  localparam logic [7:0] BYTE_SYNC0   = 8'hAA;
  localparam logic [7:0] BYTE_SYNC1   = 8'h55;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CSI_TYPE_RST = 8'd1;
  localparam logic [7:0] BLE_TYPE_RST = 8'd2;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);
  // room for the most results one byte can cause
  localparam logic [LVL_W-1:0] LVL_ACCEPT_MAX = LVL_W'(FIFO_DEPTH - 2);

  typedef enum logic [2:0] {
    KIND_CHAR    = 3'd0,
    KIND_LINE    = 3'd1,
    KIND_SAMPLE  = 3'd2,
    KIND_CSI_END = 3'd3,
    KIND_BLE     = 3'd4
  } kind_e;

  typedef enum logic {
    REG_CSI_TYPE = 1'b0,
    REG_BLE_TYPE = 1'b1
  } reg_idx_e;

  typedef enum logic [7:0] {
    PH_START   = 8'b0000_0001,
    PH_TEXT    = 8'b0000_0010,
    PH_SYNC    = 8'b0000_0100,
    PH_TYPE    = 8'b0000_1000,
    PH_LEN_LO  = 8'b0001_0000,
    PH_LEN_HI  = 8'b0010_0000,
    PH_PAYLOAD = 8'b0100_0000,
    PH_CHECK   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic               good;
    logic signed [15:0] strength;
    logic [7:0]         count;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  typedef struct packed {
    logic [7:0] csi_type;
    logic [7:0] ble_type;
  } cfg_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
  } fifo_stat_t;

endpackage

/* rtl/sfts_parse.sv */
module sfts_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_i,
  input  logic [7:0]        byte_i,
  input  sfts_pkg::cfg_t    cfg_i,
  output sfts_pkg::push_t   push_o
);
  import sfts_pkg::*;

  phase_e      phase_q, phase_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] len_q, len_d;
  logic [15:0] idx_q, idx_d;
  logic [15:0] idx_inc;
  logic [15:0] len_full;
  logic [7:0]  xor_q, xor_d;
  logic [23:0] ftb_q, ftb_d;
  logic        cr_q, cr_d;

  logic        is_csi, is_ble, match;
  logic signed [15:0] csi_str;
  res_t        plain_res;
  logic        plain_emit;
  push_t       push;

  assign is_csi   = (type_q == cfg_i.csi_type);
  assign is_ble   = (type_q == cfg_i.ble_type);
  assign match    = (xor_q == byte_i);
  assign csi_str  = (len_q != 16'd0) ? {{8{ftb_q[7]}}, ftb_q[7:0]} : 16'sd0;
  assign idx_inc  = idx_q + 16'd1;
  assign len_full = {byte_i, len_q[7:0]};

  // text byte with no carriage return pending
  always_comb begin
    plain_res      = '0;
    plain_emit     = (byte_i != CH_CR);
    if (byte_i == CH_LF) begin
      plain_res.kind = KIND_LINE;
    end else begin
      plain_res.kind = KIND_CHAR;
      plain_res.data = byte_i;
    end
  end

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    len_d   = len_q;
    idx_d   = idx_q;
    xor_d   = xor_q;
    ftb_d   = ftb_q;
    cr_d    = cr_q;
    push    = '0;
    if (acc_i) begin
      case (phase_q)
        PH_TEXT: begin
          if (cr_q && byte_i == CH_LF) begin
            push.r0.kind = KIND_LINE;
            push.n       = 2'd1;
            phase_d      = PH_START;
            cr_d         = 1'b0;
          end else begin
            if (cr_q) begin
              push.r0.kind = KIND_CHAR;
              push.r0.data = CH_CR;
              push.n       = 2'd1;
            end
            if (plain_emit) begin
              if (cr_q) begin
                push.r1 = plain_res;
                push.n  = 2'd2;
              end else begin
                push.r0 = plain_res;
                push.n  = 2'd1;
              end
            end
            cr_d    = (byte_i == CH_CR);
            phase_d = (byte_i == CH_LF) ? PH_START : PH_TEXT;
          end
        end
        PH_TYPE: begin
          type_d  = byte_i;
          xor_d   = 8'd0;
          idx_d   = 16'd0;
          len_d   = 16'd0;
          ftb_d   = 24'd0;
          phase_d = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          len_d   = {8'd0, byte_i};
          phase_d = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          len_d   = len_full;
          phase_d = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          if (idx_q == 16'd0) ftb_d[7:0]   = byte_i;
          if (idx_q == 16'd1) ftb_d[15:8]  = byte_i;
          if (idx_q == 16'd2) ftb_d[23:16] = byte_i;
          xor_d = xor_q ^ byte_i;
          // byte 0 gives no sample; it feeds the strength field and the checksum
          if (is_csi && idx_q != 16'd0) begin
            push.r0.kind     = KIND_SAMPLE;
            push.r0.data     = byte_i;
            push.r0.strength = csi_str;
            push.n           = 2'd1;
          end
          idx_d = idx_inc;
          if (idx_inc >= len_q) phase_d = PH_CHECK;
        end
        PH_CHECK: begin
          if (is_csi) begin
            push.r0.kind     = KIND_CSI_END;
            push.r0.good     = match && (len_q != 16'd0);
            push.r0.strength = csi_str;
            push.n           = 2'd1;
          end else if (is_ble && match && len_q >= 16'd3) begin
            push.r0.kind     = KIND_BLE;
            push.r0.strength = ftb_q[15:0];
            push.r0.count    = ftb_q[23:16];
            push.n           = 2'd1;
          end
          phase_d = PH_START;
        end
        default: begin
          // item start, and a sync byte that was not followed by its partner
          if (phase_q == PH_SYNC && byte_i == BYTE_SYNC1) begin
            phase_d = PH_TYPE;
          end else if (byte_i == BYTE_SYNC0) begin
            phase_d = PH_SYNC;
          end else begin
            if (plain_emit) begin
              push.r0 = plain_res;
              push.n  = 2'd1;
            end
            cr_d    = (byte_i == CH_CR);
            phase_d = (byte_i == CH_LF) ? PH_START : PH_TEXT;
          end
        end
      endcase
      if (push.n == 2'd1) push.r0.last = 1'b1;
      if (push.n == 2'd2) push.r1.last = 1'b1;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      type_q  <= 8'd0;
      len_q   <= 16'd0;
      idx_q   <= 16'd0;
      xor_q   <= 8'd0;
      ftb_q   <= 24'd0;
      cr_q    <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      xor_q   <= xor_d;
      ftb_q   <= ftb_d;
      cr_q    <= cr_d;
    end
  end

endmodule

/* rtl/sfts_fifo.sv */
module sfts_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfts_pkg::push_t      push_i,
  input  logic                 pop_i,
  output sfts_pkg::res_t       head_o,
  output sfts_pkg::fifo_stat_t stat_o
);
  import sfts_pkg::*;

  res_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, wptr_d;
  logic [FIFO_AW-1:0] rptr_q, rptr_d;
  logic [LVL_W-1:0]   level_q, level_d;
  logic [FIFO_AW-1:0] wptr_nx;

  assign wptr_nx = wptr_q + FIFO_AW'(1);
  assign wptr_d  = wptr_q + FIFO_AW'(push_i.n);
  assign rptr_d  = pop_i ? rptr_q + FIFO_AW'(1) : rptr_q;
  assign level_d = level_q + LVL_W'(push_i.n) - LVL_W'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wptr_q]  <= push_i.r0;
    if (push_i.n == 2'd2) mem_q[wptr_nx] <= push_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      level_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      level_q <= level_d;
    end
  end

  assign head_o       = mem_q[rptr_q];
  assign stat_o.level = level_q;

endmodule

/* rtl/sync_frame_and_text_line_splitter_top.sv */
// Serial deframer: splits a byte stream into text lines and sync-word framed
// binary records (type, 16-bit little-endian length, payload, xor checksum).
// Input channel: one byte per beat on byte_in_i (in_valid_i / in_stall_o).
// Output channel: one result per beat (out_valid_o / out_stall_i); a byte
// causes zero, one or two results, the last of them flagged by last_o.
// Config port: cfg_we_i writes cfg_data_i to the type code chosen by
// cfg_index_i (0 csi, 1 ble); write only while the block is idle.
// The parser updates its state in the accept cycle and writes the
// results into a four-entry result queue, which registers them; a result
// is offered once the results queued ahead of it have been taken.
// Throughput: one byte per cycle while the receiver does not stall and each
// byte causes at most one result; the single-result output port bounds the
// rate when bytes cause two. in_stall_o rises when the queue has fewer than
// two free entries, so a stalled receiver fills the queue and then holds off
// the sender; nothing is dropped. Reset empties the queue, returns the parser
// to line start and loads the type codes with 1 (csi) and 2 (ble).
module sync_frame_and_text_line_splitter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [7:0]         byte_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         item_kind_o,
  output logic [7:0]         data_byte_o,
  output logic               frame_good_o,
  output logic signed [15:0] signal_strength_o,
  output logic [7:0]         device_count_o,
  output logic               last_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import sfts_pkg::*;

  `include "assert_macros.svh"

  cfg_t       cfg_q;
  push_t      push;
  res_t       head;
  fifo_stat_t fstat;
  logic       in_acc;
  logic       pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.csi_type <= CSI_TYPE_RST;
      cfg_q.ble_type <= BLE_TYPE_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_CSI_TYPE: cfg_q.csi_type <= cfg_data_i;
        REG_BLE_TYPE: cfg_q.ble_type <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o  = (fstat.level > LVL_ACCEPT_MAX);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (fstat.level != '0);
  assign pop         = out_valid_o && !out_stall_i;

  sfts_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (in_acc),
    .byte_i (byte_in_i),
    .cfg_i  (cfg_q),
    .push_o (push)
  );

  sfts_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (fstat)
  );

  assign item_kind_o       = head.kind;
  assign data_byte_o       = head.data;
  assign frame_good_o      = head.good;
  assign signal_strength_o = head.strength;
  assign device_count_o    = head.count;
  assign last_o            = head.last;

  `SFTS_ASSERT_IMPL(a_level_bound, 1'b1, fstat.level <= LVL_W'(FIFO_DEPTH))
  `SFTS_ASSERT_IMPL(a_text_clean, out_valid_o && (head.kind == KIND_CHAR || head.kind == KIND_LINE), signal_strength_o == 16'sd0 && !frame_good_o && device_count_o == 8'd0)
  `SFTS_ASSERT_IMPL(a_count_ble_only, out_valid_o && head.kind != KIND_BLE, device_count_o == 8'd0)
  `SFTS_ASSERT_NEXT(a_level_hold, push.n == 2'd0 && !pop, $stable(fstat.level))

endmodule

/* bench/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sfts_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_AFTER_BYTES = 500;
  localparam int HOLD_CYCLES = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         byte_in_i = 8'h00;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         item_kind_o;
  logic [7:0]         data_byte_o;
  logic               frame_good_o;
  logic signed [15:0] signal_strength_o;
  logic [7:0]         device_count_o;
  logic               last_o;
  logic               cfg_we_i = 1'b0;
  logic               cfg_index_i = 1'b0;
  logic [7:0]         cfg_data_i = 8'h00;

  sync_frame_and_text_line_splitter_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .byte_in_i         (byte_in_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .item_kind_o       (item_kind_o),
    .data_byte_o       (data_byte_o),
    .frame_good_o      (frame_good_o),
    .signal_strength_o (signal_strength_o),
    .device_count_o    (device_count_o),
    .last_o            (last_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // deframer state as the bench sees it
  phase_e      parse_ph = PH_START;
  logic [7:0]  frm_type = 8'h00;
  logic [15:0] frm_len = 16'h0000;
  logic [15:0] frm_pos = 16'h0000;
  logic [7:0]  frm_xor = 8'h00;
  logic [23:0] frm_head = 24'h000000;
  logic        cr_held = 1'b0;
  logic [7:0]  csi_code = CSI_TYPE_RST;
  logic [7:0]  ble_code = BLE_TYPE_RST;

  res_t       beat_res[$];
  res_t       expected_results[$];
  logic [7:0] pending_bytes[$];
  logic [7:0] stim_bytes[$];
  logic [7:0] carry_bytes[$];

  int   err_count = 0;
  int   cycle_count = 0;
  int   bytes_taken = 0;
  int   send_gap_pct = 0;
  int   recv_gap_pct = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic hold_active = 1'b0;

  task automatic report_mismatch(input string what);
    if (err_count < 50) $display("mismatch at %0t ns: %s", $time, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  function automatic logic [15:0] csi_level();
    if (frm_len == 16'h0000) return 16'h0000;
    return {{8{frm_head[7]}}, frm_head[7:0]};
  endfunction

  task automatic add_result(input kind_e k, input logic [7:0] d, input logic g,
                            input logic [15:0] s, input logic [7:0] c);
    res_t r;
    r.kind = k;
    r.data = d;
    r.good = g;
    r.strength = s;
    r.count = c;
    r.last = 1'b0;
    beat_res = {beat_res, r};
  endtask

  task automatic text_step(input logic [7:0] b);
    if (cr_held) begin
      cr_held = 1'b0;
      if (b == CH_LF) begin
        add_result(KIND_LINE, 8'h00, 1'b0, 16'h0000, 8'h00);
        parse_ph = PH_START;
        return;
      end
      // held cr was not part of a line end
      add_result(KIND_CHAR, CH_CR, 1'b0, 16'h0000, 8'h00);
    end
    if (b == CH_LF) begin
      add_result(KIND_LINE, 8'h00, 1'b0, 16'h0000, 8'h00);
      parse_ph = PH_START;
    end else if (b == CH_CR) begin
      cr_held = 1'b1;
      parse_ph = PH_TEXT;
    end else begin
      add_result(KIND_CHAR, b, 1'b0, 16'h0000, 8'h00);
      parse_ph = PH_TEXT;
    end
  endtask

  task automatic line_start_step(input logic [7:0] b);
    if (b == BYTE_SYNC0) begin
      parse_ph = PH_SYNC;
    end else begin
      cr_held = 1'b0;
      text_step(b);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    res_t r;
    beat_res.delete();
    case (parse_ph)
      PH_TEXT: text_step(b);
      PH_SYNC: begin
        if (b == BYTE_SYNC1) parse_ph = PH_TYPE;
        else line_start_step(b);
      end
      PH_TYPE: begin
        frm_type = b;
        frm_xor = 8'h00;
        frm_pos = 16'h0000;
        frm_len = 16'h0000;
        frm_head = 24'h000000;
        parse_ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frm_len = {8'h00, b};
        parse_ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        frm_len[15:8] = b;
        parse_ph = (frm_len == 16'h0000) ? PH_CHECK : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (frm_pos < 3) frm_head[8*frm_pos +: 8] = b;
        frm_xor ^= b;
        // byte 0 gives no sample; it sets the strength and enters the checksum
        if (frm_type == csi_code && frm_pos >= 1)
          add_result(KIND_SAMPLE, b, 1'b0, csi_level(), 8'h00);
        frm_pos++;
        if (frm_pos >= frm_len) parse_ph = PH_CHECK;
      end
      PH_CHECK: begin
        if (frm_type == csi_code) begin
          add_result(KIND_CSI_END, 8'h00, frm_xor == b && frm_len != 16'h0000,
                     csi_level(), 8'h00);
        end else if (frm_type == ble_code) begin
          if (frm_xor == b && frm_len >= 3)
            add_result(KIND_BLE, 8'h00, 1'b0, frm_head[15:0], frm_head[23:16]);
        end
        parse_ph = PH_START;
      end
      default: line_start_step(b);
    endcase
    foreach (beat_res[i]) begin
      r = beat_res[i];
      r.last = (i == beat_res.size() - 1);
      expected_results = {expected_results, r};
    end
  endtask

  // sender: holds a stalled beat, otherwise idles in bursts or takes the next byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      byte_in_i <= 8'h00;
      send_gap = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0 && !hold_active &&
                   $urandom_range(0, 99) < send_gap_pct) begin
        send_gap = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (pending_bytes.size() > 0) begin
        in_valid_i <= 1'b1;
        byte_in_i <= pending_bytes.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off to back up the block
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_active <= 1'b0;
      recv_gap = 0;
    end else begin
      if (!hold_done && bytes_taken >= HOLD_AFTER_BYTES) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        hold_active <= 1'b1;
        out_stall_i <= 1'b1;
      end else begin
        hold_active <= 1'b0;
        if (recv_gap > 0) begin
          recv_gap--;
          out_stall_i <= 1'b1;
        end else if ($urandom_range(0, 99) < recv_gap_pct) begin
          recv_gap = $urandom_range(0, 14);
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watch
    res_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        deframe_byte(byte_in_i);
        bytes_taken <= bytes_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind %0d", item_kind_o));
        end else begin
          want = expected_results.pop_front();
          check_field("item_kind", 16'(item_kind_o), 16'(want.kind));
          check_field("data_byte", 16'(data_byte_o), 16'(want.data));
          check_field("frame_good", 16'(frame_good_o), 16'(want.good));
          check_field("signal_strength", signal_strength_o, want.strength);
          check_field("device_count", 16'(device_count_o), 16'(want.count));
          check_field("last", 16'(last_o), 16'(want.last));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic write_type_code(input reg_idx_e idx, input logic [7:0] code);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= code;
    if (idx == REG_CSI_TYPE) csi_code = code;
    else ble_code = code;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every byte is in and every result is out, then let the pipe drain
  task automatic settle();
    do @(negedge clk_i);
    while (pending_bytes.size() != 0 || in_valid_i || expected_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_frame_type();
    logic [7:0] t;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return csi_code;
    if (r < 75) return ble_code;
    do t = 8'($urandom_range(0, 255));
    while (t == csi_code || t == ble_code);
    return t;
  endfunction

  task automatic add_frame(input logic [7:0] ftype, input int len, input bit sum_ok);
    logic [7:0] sum;
    logic [7:0] p;
    sum = 8'h00;
    stim_bytes = {stim_bytes, BYTE_SYNC0};
    stim_bytes = {stim_bytes, BYTE_SYNC1};
    stim_bytes = {stim_bytes, ftype};
    stim_bytes = {stim_bytes, len[7:0]};
    stim_bytes = {stim_bytes, len[15:8]};
    for (int i = 0; i < len; i++) begin
      p = 8'($urandom_range(0, 255));
      sum ^= p;
      stim_bytes = {stim_bytes, p};
    end
    if (!sum_ok) sum ^= 8'($urandom_range(1, 255));
    stim_bytes = {stim_bytes, sum};
  endtask

  // each unit leaves the parser back at line start
  task automatic random_unit();
    int pick;
    int n;
    int len;
    logic [7:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      n = $urandom_range(0, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) c = CH_CR;
        else c = 8'($urandom_range(0, 255));
        if (c == CH_LF || (i == 0 && c == BYTE_SYNC0)) c = 8'h20;
        stim_bytes = {stim_bytes, c};
      end
      if ($urandom_range(0, 2) == 0) stim_bytes = {stim_bytes, CH_CR};
      stim_bytes = {stim_bytes, CH_LF};
    end else if (pick < 75) begin
      case ($urandom_range(0, 9))
        0: len = 0;
        7, 8: len = 3;
        9: len = $urandom_range(7, 40);
        default: len = $urandom_range(1, 6);
      endcase
      add_frame(pick_frame_type(), len, $urandom_range(0, 4) != 0);
    end else if (pick < 87) begin
      // lone sync byte
      do c = 8'($urandom_range(0, 255));
      while (c == BYTE_SYNC1);
      stim_bytes = {stim_bytes, BYTE_SYNC0};
      stim_bytes = {stim_bytes, c};
      stim_bytes = {stim_bytes, CH_LF};
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        do c = 8'($urandom_range(0, 255));
        while (c == BYTE_SYNC1);
        stim_bytes = {stim_bytes, c};
      end
      stim_bytes = {stim_bytes, CH_LF};
    end
  endtask

  initial begin
    logic [7:0] csi_v;
    logic [7:0] ble_v;
    int target;
    int len;
    int cut_n;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // line ends, cr handling, sync slip, a csi and a ble frame at reset codes
    @(negedge clk_i);
    pending_bytes = {8'h0A, 8'h00, 8'hFF, 8'h0D, 8'h41, 8'h0D, 8'h0A,
                     8'hAA, 8'h12, 8'hAA, 8'h0A,
                     8'hAA, 8'hAA, 8'h55, 8'h01, 8'h02, 8'h00, 8'h80, 8'h7F, 8'hFF,
                     8'hAA, 8'h55, 8'h02, 8'h03, 8'h00, 8'h01, 8'h02, 8'h03, 8'h00};
    settle();

    for (int ph = 0; ph < 7; ph++) begin
      csi_v = 8'($urandom_range(0, 255));
      ble_v = 8'($urandom_range(0, 255));
      case (ph)
        0: begin csi_v = 8'h01; ble_v = 8'h02; send_gap_pct = 10; recv_gap_pct = 10; end
        1: begin csi_v = 8'h00; ble_v = 8'hFF; send_gap_pct = 5; recv_gap_pct = 20; end
        2: begin csi_v = 8'hFF; ble_v = 8'h00; send_gap_pct = 20; recv_gap_pct = 5; end
        3: begin csi_v = 8'h07; ble_v = 8'h07; send_gap_pct = 10; recv_gap_pct = 10; end
        4: begin send_gap_pct = 15; recv_gap_pct = 15; end
        5: begin send_gap_pct = 0; recv_gap_pct = 30; end
        default: begin send_gap_pct = 0; recv_gap_pct = 0; end
      endcase
      if (ph[0]) begin
        write_type_code(REG_BLE_TYPE, ble_v);
        write_type_code(REG_CSI_TYPE, csi_v);
      end else begin
        write_type_code(REG_CSI_TYPE, csi_v);
        write_type_code(REG_BLE_TYPE, ble_v);
      end

      // a frame cut at the end of the last phase resumes under the new codes
      stim_bytes = carry_bytes;
      carry_bytes.delete();
      if (ph == 2) add_frame(csi_code, 300, 1'b1);
      target = stim_bytes.size() + 200;
      while (stim_bytes.size() < target) random_unit();
      if (ph < 6 && $urandom_range(0, 1) == 1) begin
        len = $urandom_range(4, 10);
        add_frame(pick_frame_type(), len, $urandom_range(0, 3) != 0);
        cut_n = $urandom_range(1, len + 1);
        repeat (cut_n) carry_bytes.push_front(stim_bytes.pop_back());
      end

      @(negedge clk_i);
      pending_bytes = stim_bytes;
      settle();
    end

    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl
rtl/sfts_pkg.sv
rtl/sfts_parse.sv
rtl/sfts_fifo.sv
rtl/sync_frame_and_text_line_splitter_top.sv
bench/testbench.sv
